// ===== rtl/sha_mp_pkg.sv =====
// Package for the SHA-256 message padder: sequencer states, pad constants,
// and the control/status structs between the sequencer and the byte packer.
// No dependencies.
`timescale 1ns / 1ps

package sha_mp_pkg;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [2:0] LEN_BYTES_M = 3'd7;   // index of the last length byte

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef enum logic [1:0] {
      ST_MSG,    // taking message bytes
      ST_MARK,   // pushing the 0x80 marker
      ST_ZERO,   // pushing zeros up to the length field
      ST_LEN     // pushing the 64-bit bit count, MSB first
   } state_type;

   // byte push from the sequencer into the packer
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last_msg;
   } push_type;

   // packer status back to the sequencer
   typedef struct packed {
      logic       ready;
      logic [5:0] pos;
   } pk_stat_type;

endpackage

// ===== rtl/sha_mp_if.sv =====
// Valid/ready channel interfaces for the request beats and the word beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface sha_mp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sha_mp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] word;
   logic        block_last;
   logic        message_last;

   modport source (output valid, output word, output block_last, output message_last,
                   input ready);
   modport sink   (input valid, input word, input block_last, input message_last,
                   output ready);
endinterface

// ===== rtl/sha256_message_padder.sv =====
// SHA-256 message padder top: pad sequencer, bit counter and the shared packer.
// Message byte beats: one per cycle unless the output stalls; a word shows on
// rsp_bus the cycle after its eighth byte. End beat: packer takes the pad bytes
// in order (0x80, zeros, eight length bytes); req_bus ready again after the last.
// Output stalls hold the packer. Synchronous reset clears position, partial
// word, bit count and sequencer; a new message then starts at block byte 0.
`timescale 1ns / 1ps

module sha256_message_padder (
   input  logic         clock,
   input  logic         reset,
   sha_mp_req_if.sink   req_bus,
   sha_mp_rsp_if.source rsp_bus
);
   import sha_mp_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] bit_count_ff, bit_count_in;  // shifted left a byte per length push
   logic [2:0]  len_idx_ff, len_idx_in;

   push_type    push;
   pk_stat_type stat;
   logic        req_take;

   // request side is open only while collecting message bytes
   assign req_bus.ready = (state_ff == ST_MSG) && stat.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_MSG: begin
            if (req_take && (req_bus.command == CMD_END)) state_in = ST_MARK;
         end
         ST_MARK: begin
            if (stat.ready) state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (stat.pos == LEN_POS) state_in = ST_LEN;
         end
         ST_LEN: begin
            if (stat.ready && (len_idx_ff == LEN_BYTES_M)) state_in = ST_MSG;
         end
         default: state_in = ST_MSG;
      endcase
   end

   // outputs: byte push into the packer, counter updates
   always_comb begin
      push.valid    = 1'b0;
      push.data     = req_bus.data_byte;
      push.last_msg = 1'b0;
      bit_count_in  = bit_count_ff;
      len_idx_in    = len_idx_ff;
      unique case (state_ff)
         ST_MSG: begin
            if (req_take && (req_bus.command == CMD_BYTE)) begin
               push.valid   = 1'b1;
               bit_count_in = bit_count_ff + 64'd8;   // wraps mod 2^64
            end
         end
         ST_MARK: begin
            push.valid = 1'b1;
            push.data  = PAD_MARK;
         end
         ST_ZERO: begin
            // at the length field: no push, then on to the length bytes
            push.valid = (stat.pos != LEN_POS);
            push.data  = 8'h00;
         end
         ST_LEN: begin
            push.valid    = 1'b1;
            push.data     = bit_count_ff[63:56];
            push.last_msg = (len_idx_ff == LEN_BYTES_M);
            if (stat.ready) begin
               // eight shifts leave the count at zero for the next message
               bit_count_in = {bit_count_ff[55:0], 8'h00};
               len_idx_in   = len_idx_ff + 3'd1;
            end
         end
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MSG;
         bit_count_ff <= '0;
         len_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         bit_count_ff <= bit_count_in;
         len_idx_ff   <= len_idx_in;
      end
   end

   sha_mp_packer u_packer (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== rtl/sha_mp_packer.sv =====
// Shared byte packer: shifts bytes into a 64-bit big-endian word and holds
// finished words in an output register. Depends on sha_mp_pkg, sha_mp_rsp_if.
`timescale 1ns / 1ps

module sha_mp_packer (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_mp_pkg::push_type   push,
   output sha_mp_pkg::pk_stat_type stat,
   sha_mp_rsp_if.source           rsp_bus
);
   import sha_mp_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [55:0] partial_ff, partial_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] word_ff, word_in;
   logic        blast_ff, blast_in;
   logic        mlast_ff, mlast_in;

   logic        ready;
   logic        take;
   logic        done;
   logic [63:0] packed_word;

   assign ready       = !out_valid_ff || rsp_bus.ready;
   assign take        = push.valid && ready;
   assign packed_word = {partial_ff, push.data};
   assign done        = (pos_ff[2:0] == 3'd7);

   always_comb begin
      pos_in       = pos_ff;
      partial_in   = partial_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      word_in      = word_ff;
      blast_in     = blast_ff;
      mlast_in     = mlast_ff;
      if (take) begin
         pos_in = pos_ff + 6'd1;
         if (done) begin
            partial_in   = '0;
            out_valid_in = 1'b1;
            word_in      = packed_word;
            blast_in     = (pos_ff == 6'd63);
            mlast_in     = push.last_msg;
         end else begin
            partial_in = packed_word[55:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         partial_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
      end
      word_ff  <= word_in;
      blast_ff <= blast_in;
      mlast_ff <= mlast_in;
   end

   assign stat.ready           = ready;
   assign stat.pos             = pos_ff;
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.word         = word_ff;
   assign rsp_bus.block_last   = blast_ff;
   assign rsp_bus.message_last = mlast_ff;

endmodule
